// File: hdl/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 hash core package
// Shared payload types and hash constants.
// ----------------------------------------------------------------------------
package sha1h_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

endpackage

// File: hdl/sha1h_queue.sv
// ----------------------------------------------------------------------------
// SHA-1 input queue
// Small FIFO between the byte front end and the hash engine.
// ----------------------------------------------------------------------------
module sha1h_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_stall,
	input  sha1h_pkg::in_item_t wr_data,
	output logic                rd_valid,
	input  logic                rd_take,
	output sha1h_pkg::in_item_t rd_data
);
	import sha1h_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t         mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && rd_take;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: hdl/sha1h_engine.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Absorbs bytes into a 16-word schedule, runs one round per cycle,
// pads on finish and emits the five digest words.
// ----------------------------------------------------------------------------
module sha1h_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_take,
	input  sha1h_pkg::in_item_t  item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output sha1h_pkg::out_item_t res
);
	import sha1h_pkg::*;

	typedef enum logic [2:0] {
		ST_BYTE, ST_ROUND, ST_PADZ, ST_LEN, ST_EMIT
	} state_t;

	state_t       state_q;
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic         fin_q;
	logic         last_blk_q;
	logic [3:0]   len_q;
	logic [2:0]   idx_q;
	logic         res_valid_q;
	out_item_t    res_q;

	logic [31:0]  w_new, w_cur, f, k, t;
	logic [63:0]  bits;
	logic         out_free;

	assign bits     = {total_q, 3'b000};
	assign out_free = !res_valid_q || !res_stall;
	assign item_take = (state_q == ST_BYTE) && item_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
		w_cur = (rnd_q < 7'd16) ? w_q[0] : w_new;
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BYTE;
			h_q         <= '{H0, H1, H2, H3, H4};
			rnd_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			fin_q       <= 1'b0;
			last_blk_q  <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_BYTE: begin
					if (item_valid) begin
						w_q[15] <= {w_q[15][23:0],
							(item.cmd == CMD_ABSORB) ? item.data_byte : PAD_BYTE};
						fill_q <= fill_q + 1'b1;
						if (fill_q[1:0] == 2'd0) begin
							for (int i = 0; i < 15; i++) begin
								w_q[i] <= w_q[i+1];
							end
						end
						if (item.cmd == CMD_ABSORB) begin
							total_q <= total_q + 1'b1;
							if (fill_q == 6'd63) begin
								state_q <= ST_ROUND;
								rnd_q   <= '0;
								last_blk_q <= 1'b0;
								{a_q, b_q, c_q, d_q, e_q} <=
									{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
							end
						end else begin
							fin_q   <= 1'b1;
							if (fill_q == 6'd63) begin
								state_q    <= ST_ROUND;
								rnd_q      <= '0;
								last_blk_q <= 1'b0;
								{a_q, b_q, c_q, d_q, e_q} <=
									{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
							end else begin
								state_q <= ST_PADZ;
							end
						end
					end
				end
				ST_PADZ: begin
					if (fill_q == 6'd56 && len_q == 4'd0 && fin_q) begin
						state_q <= ST_LEN;
						len_q   <= 4'd8;
					end else begin
						w_q[15] <= {w_q[15][23:0], 8'h00};
						fill_q  <= fill_q + 1'b1;
						if (fill_q[1:0] == 2'd0) begin
							for (int i = 0; i < 15; i++) begin
								w_q[i] <= w_q[i+1];
							end
						end
						if (fill_q == 6'd63) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							last_blk_q <= 1'b0;
							{a_q, b_q, c_q, d_q, e_q} <=
								{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
						end
					end
				end
				ST_LEN: begin
					w_q[15] <= {w_q[15][23:0], bits[8*len_q-1 -: 8]};
					fill_q  <= fill_q + 1'b1;
					len_q   <= len_q - 1'b1;
					if (fill_q[1:0] == 2'd0) begin
						for (int i = 0; i < 15; i++) begin
							w_q[i] <= w_q[i+1];
						end
					end
					if (fill_q == 6'd63) begin
						state_q    <= ST_ROUND;
						rnd_q      <= '0;
						last_blk_q <= 1'b1;
						{a_q, b_q, c_q, d_q, e_q} <=
							{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i+1];
					end
					w_q[15] <= w_cur;
					e_q <= d_q;
					d_q <= c_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q;
					a_q <= t;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'd79) begin
						h_q[0] <= h_q[0] + t;
						h_q[1] <= h_q[1] + a_q;
						h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
						h_q[3] <= h_q[3] + c_q;
						h_q[4] <= h_q[4] + d_q;
						if (last_blk_q) begin
							state_q <= ST_EMIT;
							idx_q   <= '0;
						end else if (fin_q) begin
							state_q <= ST_PADZ;
						end else begin
							state_q <= ST_BYTE;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q       <= 1'b1;
						res_q.digest_word <= h_q[idx_q];
						res_q.word_index  <= idx_q;
						res_q.last_word   <= (idx_q == 3'd4);
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd4) begin
							state_q    <= ST_BYTE;
							h_q        <= '{H0, H1, H2, H3, H4};
							total_q    <= '0;
							fill_q     <= '0;
							fin_q      <= 1'b0;
							last_blk_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_BYTE;
			endcase
		end
	end

endmodule

// File: hdl/sha1_message_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-1 message hash core
// Byte-wide SHA-1 with front queue and iterative round engine.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in      | in  | in_valid/stall   | cmd, data_byte
//  out     | out | out_valid/stall  | digest_word, word_index, last_word
//
// Bytes are absorbed one at a time into the schedule; each full block adds 80
// rounds, one per cycle. Finish takes the padding bytes (one per cycle,
// up to two blocks) plus 80 rounds per block, then five output transfers.
// Reset leaves the initial chaining values loaded and the byte count clear.
// The input queue absorbs bytes while the engine runs rounds.
module sha1_message_hash_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sha1h_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sha1h_pkg::out_item_t out_item
);
	import sha1h_pkg::*;

	logic     q_valid, q_take;
	in_item_t q_item;

	sha1h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_item),
		.rd_valid(q_valid), .rd_take(q_take), .rd_data(q_item)
	);

	sha1h_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.item_valid(q_valid), .item_take(q_take), .item(q_item),
		.res_valid(out_valid), .res_stall(out_stall), .res(out_item)
	);

endmodule

// File: hdl/sha1h_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 core port checker
// Port-level properties of the digest output.
// ----------------------------------------------------------------------------
module sha1h_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input sha1h_pkg::out_item_t out_item
);
	import sha1h_pkg::*;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.word_index <= 3'd4)
		else $error("word index out of range");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last_word == (out_item.word_index == 3'd4)))
		else $error("last flag mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

endmodule

bind sha1_message_hash_core sha1h_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_item(out_item)
);
